>>> src/pfa_pkg.sv
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared types and constants for the attractor force accumulator.
// ----------------------------------------------------------------------------
package pfa_pkg;

   localparam int unsigned MAX_ATTRACTORS_DEF = 1024;

   // Softening term 1e-5 and direction threshold 1e-4, both in 2^-32 units
   localparam logic [36:0] EPS_Q32       = 37'd42950;
   localparam logic [35:0] SYM_LIMIT_Q32 = 36'd429497;

   localparam int unsigned NUM_W = 52;   // |d| * mass * 2^16
   localparam int unsigned DEN_W = 37;   // r2 + eps

   typedef enum logic [1:0] {
      KIND_ADD   = 2'd0,
      KIND_CLEAR = 2'd1,
      KIND_EVAL  = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   typedef struct packed {
      logic signed [17:0] pos_x;
      logic signed [17:0] pos_y;
      logic signed [17:0] dir_x;
      logic signed [17:0] dir_y;
      logic        [17:0] mass;
   } attractor_type;

   typedef struct packed {
      logic                      start;
      logic [NUM_W-1:0]          num_x;
      logic [NUM_W-1:0]          num_y;
      logic [DEN_W-1:0]          den;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [NUM_W-1:0] quot_x;
      logic [NUM_W-1:0] quot_y;
   } div_rsp_type;

endpackage

>>> src/planet_force_accumulator_core.sv
// Add and clear give no result.
// Evaluate: for N stored attractors the result is offered after, per attractor, one
// table read, the multiplier steps, the divider run including start and done, and one
// accumulate; an empty table offers it in the next cycle.
// One item at a time; req_ready only in idle.
// Reset clears the attractor count and the sequencer; table contents stay.
// ----------------------------------------------------------------------------
// planet_force_accumulator_core
// Attractor table with a sequenced softened-gravity force evaluator.
// ----------------------------------------------------------------------------
module planet_force_accumulator_core #(
   parameter int unsigned MAX_ATTRACTORS = pfa_pkg::MAX_ATTRACTORS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_kind,
   input  logic signed [17:0] req_pos_x,
   input  logic signed [17:0] req_pos_y,
   input  logic signed [17:0] req_dir_x,
   input  logic signed [17:0] req_dir_y,
   input  logic [17:0]        req_mass,
   input  logic signed [31:0] req_force_in_x,
   input  logic signed [31:0] req_force_in_y,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_force_x,
   output logic signed [31:0] rsp_force_y,
   output logic               rsp_saturated
);

   localparam int unsigned AW = (MAX_ATTRACTORS > 1) ? $clog2(MAX_ATTRACTORS) : 1;
   localparam int unsigned CW = $clog2(MAX_ATTRACTORS + 1);
   localparam int unsigned NW = pfa_pkg::NUM_W;
   localparam int unsigned SW = NW + 2;
   localparam logic signed [SW-1:0] SUM_MAX = SW'(64'sd2147483647);
   localparam logic signed [SW-1:0] SUM_MIN = -SW'(64'sd2147483648);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_READ = 6'b000010,
      ST_MUL  = 6'b000100,
      ST_DIV  = 6'b001000,
      ST_ACC  = 6'b010000,
      ST_OUT  = 6'b100000
   } state_type;

   state_type             state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [CW-1:0]         idx_ff, idx_in;
   logic [3:0]            step_ff, step_in;
   logic signed [17:0]    px_ff, px_in, py_ff, py_in;
   logic signed [31:0]    fx_ff, fx_in, fy_ff, fy_in;
   logic                  sat_ff, sat_in;
   logic signed [37:0]    prod_ff;
   logic [36:0]           r2_ff, r2_in;
   logic [35:0]           dsq_ff, dsq_in;
   logic signed [37:0]    dot_ff, dot_in;
   logic [35:0]           nx_ff, nx_in, ny_ff, ny_in;

   pfa_pkg::attractor_type wr_data, rd_data;
   pfa_pkg::div_req_type   div_req;
   pfa_pkg::div_rsp_type   div_rsp;
   logic                   wr_en, rd_en;

   logic signed [18:0] ddx, ddy, adx, ady, abs_dx, abs_dy, mass_s;
   logic signed [18:0] op_a, op_b;
   logic signed [37:0] prod;
   logic               neg, flip_x, flip_y, sat_x, sat_y;
   logic signed [SW-1:0] sum_x, sum_y, term_x, term_y;
   logic signed [31:0]   clip_x, clip_y;

   pfa_table #(.MAX_ATTRACTORS(MAX_ATTRACTORS), .AW(AW)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   pfa_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign wr_data.pos_x = req_pos_x;
   assign wr_data.pos_y = req_pos_y;
   assign wr_data.dir_x = req_dir_x;
   assign wr_data.dir_y = req_dir_y;
   assign wr_data.mass  = req_mass;

   // particle minus attractor, and the operands of the shared multiplier
   always_comb begin
      ddx    = 19'(px_ff) - 19'(rd_data.pos_x);
      ddy    = 19'(py_ff) - 19'(rd_data.pos_y);
      adx    = 19'(rd_data.dir_x);
      ady    = 19'(rd_data.dir_y);
      abs_dx = ddx[18] ? -ddx : ddx;
      abs_dy = ddy[18] ? -ddy : ddy;
      mass_s = {1'b0, rd_data.mass};
      unique case (step_ff[2:0])
         3'd0: begin op_a = ddx;    op_b = ddx;    end
         3'd1: begin op_a = ddy;    op_b = ddy;    end
         3'd2: begin op_a = adx;    op_b = adx;    end
         3'd3: begin op_a = ady;    op_b = ady;    end
         3'd4: begin op_a = ddx;    op_b = adx;    end
         3'd5: begin op_a = ddy;    op_b = ady;    end
         3'd6: begin op_a = abs_dx; op_b = mass_s; end
         default: begin op_a = abs_dy; op_b = mass_s; end
      endcase
      prod = op_a * op_b;
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod;
   end

   // accumulate step: apply the sign, add, clamp to Q15.16
   always_comb begin
      neg    = (dsq_ff < pfa_pkg::SYM_LIMIT_Q32) || dot_ff[37];
      flip_x = ddx[18] ^ neg;
      flip_y = ddy[18] ^ neg;
      term_x = flip_x ? -$signed({2'b00, div_rsp.quot_x}) : $signed({2'b00, div_rsp.quot_x});
      term_y = flip_y ? -$signed({2'b00, div_rsp.quot_y}) : $signed({2'b00, div_rsp.quot_y});
      sum_x  = SW'(fx_ff) + term_x;
      sum_y  = SW'(fy_ff) + term_y;
      sat_x  = 1'b1;
      sat_y  = 1'b1;
      if (sum_x > SUM_MAX) begin
         clip_x = 32'sh7FFF_FFFF;
      end else if (sum_x < SUM_MIN) begin
         clip_x = 32'sh8000_0000;
      end else begin
         clip_x = sum_x[31:0];
         sat_x  = 1'b0;
      end
      if (sum_y > SUM_MAX) begin
         clip_y = 32'sh7FFF_FFFF;
      end else if (sum_y < SUM_MIN) begin
         clip_y = 32'sh8000_0000;
      end else begin
         clip_y = sum_y[31:0];
         sat_y  = 1'b0;
      end
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      step_in  = step_ff;
      px_in    = px_ff;
      py_in    = py_ff;
      fx_in    = fx_ff;
      fy_in    = fy_ff;
      sat_in   = sat_ff;
      r2_in    = r2_ff;
      dsq_in   = dsq_ff;
      dot_in   = dot_ff;
      nx_in    = nx_ff;
      ny_in    = ny_ff;
      wr_en    = 1'b0;
      rd_en    = 1'b0;
      div_req.start = 1'b0;
      div_req.num_x = {nx_ff, 16'd0};
      div_req.num_y = {ny_ff, 16'd0};
      div_req.den   = r2_ff + pfa_pkg::EPS_Q32;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (pfa_pkg::kind_type'(req_kind))
                  pfa_pkg::KIND_ADD: begin
                     if (count_ff < CW'(MAX_ATTRACTORS)) begin
                        wr_en    = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  pfa_pkg::KIND_CLEAR: count_in = '0;
                  pfa_pkg::KIND_EVAL: begin
                     px_in  = req_pos_x;
                     py_in  = req_pos_y;
                     fx_in  = req_force_in_x;
                     fy_in  = req_force_in_y;
                     sat_in = 1'b0;
                     idx_in = '0;
                     state_in = (count_ff == '0) ? ST_OUT : ST_READ;
                  end
                  default: ;
               endcase
            end
         end
         ST_READ: begin
            rd_en    = 1'b1;
            step_in  = '0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            // product of the previous step lands here
            unique case (step_ff)
               4'd1: r2_in  = prod_ff[36:0];
               4'd2: r2_in  = r2_ff + prod_ff[36:0];
               4'd3: dsq_in = prod_ff[35:0];
               4'd4: dsq_in = dsq_ff + prod_ff[35:0];
               4'd5: dot_in = prod_ff;
               4'd6: dot_in = dot_ff + prod_ff;
               4'd7: nx_in  = prod_ff[35:0];
               4'd8: ny_in  = prod_ff[35:0];
               default: ;
            endcase
            step_in = step_ff + 1'b1;
            if (step_ff == 4'd8) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            div_req.start = (step_ff == 4'd9);
            step_in = 4'd10;
            if (div_rsp.done && step_ff == 4'd10) begin
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            fx_in  = clip_x;
            fy_in  = clip_y;
            sat_in = sat_ff | sat_x | sat_y;
            idx_in = idx_ff + 1'b1;
            state_in = (idx_ff + 1'b1 == count_ff) ? ST_OUT : ST_READ;
         end
         ST_OUT: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         idx_ff   <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         idx_ff   <= idx_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      px_ff  <= px_in;
      py_ff  <= py_in;
      fx_ff  <= fx_in;
      fy_ff  <= fy_in;
      sat_ff <= sat_in;
      r2_ff  <= r2_in;
      dsq_ff <= dsq_in;
      dot_ff <= dot_in;
      nx_ff  <= nx_in;
      ny_ff  <= ny_in;
   end

   assign req_ready     = (state_ff == ST_IDLE);
   assign rsp_valid     = (state_ff == ST_OUT);
   assign rsp_force_x   = fx_ff;
   assign rsp_force_y   = fy_ff;
   assign rsp_saturated = sat_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_ATTRACTORS))
      else $error("attractor count beyond table depth");

   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> (idx_ff < count_ff))
      else $error("table read past stored attractors");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_DIV))
      else $error("divider finished outside divide phase");

   a_out_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(fx_ff) && $stable(sat_ff)))
      else $error("result changed while waiting");

endmodule

>>> src/pfa_table.sv
// ----------------------------------------------------------------------------
// pfa_table
// Attractor storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module pfa_table #(
   parameter int unsigned MAX_ATTRACTORS = pfa_pkg::MAX_ATTRACTORS_DEF,
   parameter int unsigned AW = (MAX_ATTRACTORS > 1) ? $clog2(MAX_ATTRACTORS) : 1
) (
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [AW-1:0]          wr_addr,
   input  pfa_pkg::attractor_type wr_data,
   input  logic                   rd_en,
   input  logic [AW-1:0]          rd_addr,
   output pfa_pkg::attractor_type rd_data
);

   pfa_pkg::attractor_type mem [MAX_ATTRACTORS];
   pfa_pkg::attractor_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/pfa_div.sv
// ----------------------------------------------------------------------------
// pfa_div
// Two-lane restoring divider, one quotient bit per lane per cycle,
// both lanes sharing one denominator.
// ----------------------------------------------------------------------------
module pfa_div (
   input  logic                 clock,
   input  logic                 reset,
   input  pfa_pkg::div_req_type req,
   output pfa_pkg::div_rsp_type rsp
);

   localparam int unsigned NW = pfa_pkg::NUM_W;
   localparam int unsigned DW = pfa_pkg::DEN_W;
   localparam int unsigned CW = $clog2(NW);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [NW-1:0] qx_ff, qx_in, qy_ff, qy_in;
   logic [DW-1:0] rx_ff, rx_in, ry_ff, ry_in;
   logic [DW-1:0] den_ff, den_in;
   logic [DW:0]   rx_sh, ry_sh, rx_diff, ry_diff;

   always_comb begin
      rx_sh   = {rx_ff, qx_ff[NW-1]};
      ry_sh   = {ry_ff, qy_ff[NW-1]};
      rx_diff = rx_sh - {1'b0, den_ff};
      ry_diff = ry_sh - {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      qx_in   = qx_ff;
      qy_in   = qy_ff;
      rx_in   = rx_ff;
      ry_in   = ry_ff;
      den_in  = den_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         qx_in   = req.num_x;
         qy_in   = req.num_y;
         rx_in   = '0;
         ry_in   = '0;
         den_in  = req.den;
      end else if (busy_ff) begin
         // shift numerator bit into remainder, quotient bit in at the bottom
         if (!rx_diff[DW]) begin
            rx_in = rx_diff[DW-1:0];
            qx_in = {qx_ff[NW-2:0], 1'b1};
         end else begin
            rx_in = rx_sh[DW-1:0];
            qx_in = {qx_ff[NW-2:0], 1'b0};
         end
         if (!ry_diff[DW]) begin
            ry_in = ry_diff[DW-1:0];
            qy_in = {qy_ff[NW-2:0], 1'b1};
         end else begin
            ry_in = ry_sh[DW-1:0];
            qy_in = {qy_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(NW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      qx_ff  <= qx_in;
      qy_ff  <= qy_in;
      rx_ff  <= rx_in;
      ry_ff  <= ry_in;
      den_ff <= den_in;
   end

   assign rsp.done   = done_ff;
   assign rsp.quot_x = qx_ff;
   assign rsp.quot_y = qy_ff;

endmodule
